FILE: src/ilid_pkg.sv
// Shared types and codes for the indexed list insert/delete block.
package ilid_pkg;

    // Request action codes
    localparam logic [2:0] ACT_GET    = 3'd0;
    localparam logic [2:0] ACT_SET    = 3'd1;
    localparam logic [2:0] ACT_INSERT = 3'd2;
    localparam logic [2:0] ACT_DELETE = 3'd3;
    localparam logic [2:0] ACT_PUSH   = 3'd4;
    localparam logic [2:0] ACT_POP    = 3'd5;

    // Port widths of the request and response fields
    localparam int ACTION_W   = 3;
    localparam int POSITION_W = 7;
    localparam int VALUE_W    = 32;
    localparam int LENGTH_W   = 7;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } chain_op_t;

endpackage

FILE: src/ilid_cell.sv
// One storage cell of the list chain: holds one element, shifts with its neighbors.
module ilid_cell
    import ilid_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 32,
    parameter int IDX_W         = 6,
    parameter int INDEX         = 0
) (
    input  logic                     aclk,
    input  chain_op_t                op,
    input  logic [IDX_W-1:0]         target,
    input  logic [ELEMENT_WIDTH-1:0] new_value,
    input  logic [ELEMENT_WIDTH-1:0] left_value,
    input  logic [ELEMENT_WIDTH-1:0] right_value,
    output logic [ELEMENT_WIDTH-1:0] value,
    output logic [ELEMENT_WIDTH-1:0] read_term
);

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

    logic [ELEMENT_WIDTH-1:0] value_reg;
    logic [ELEMENT_WIDTH-1:0] value_next;
    logic                     at_target;
    logic                     above_target;

    assign at_target    = (MY_INDEX == target);
    assign above_target = (MY_INDEX > target);

    always_comb begin
        value_next = value_reg;
        case (op)
            OP_HOLD: begin
                value_next = value_reg;
            end
            OP_WRITE: begin
                if (at_target) begin
                    value_next = new_value;
                end
            end
            OP_INSERT: begin
                // take from the lower neighbor above the slot, load the slot itself
                if (above_target) begin
                    value_next = left_value;
                end else if (at_target) begin
                    value_next = new_value;
                end
            end
            OP_REMOVE: begin
                // close the gap: everything from the slot upward takes from above
                if (above_target || at_target) begin
                    value_next = right_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    assign read_term = at_target ? value_reg : '0;

endmodule

FILE: src/indexed_list_insert_delete_top.sv
// Top level of the indexed list: request handling, cell chain and response register.
//
//  channel   | direction | handshake         | payload
//  ----------+-----------+-------------------+-------------------------------------------
//  request   | in        | s_valid / s_ready | s_action, s_position, s_item_value
//  response  | out       | m_valid / m_ready | m_status, m_read_value, m_list_length
//
// All cells of the chain shift, load or hold in parallel at the edge that
// accepts the transaction, so one transaction can be accepted each cycle
// while responses are being taken.
// The response stays in an output register; a new request is accepted when
// that register is empty or its response is taken in the same cycle.
// Reset (aresetn low, synchronous) empties the list and the response
// register; cell contents are not cleared, positions at or past the length
// are never read. A stalled response holds the request side off (s_ready low).
module indexed_list_insert_delete_top
    import ilid_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ACTION_W-1:0]   s_action,
    input  logic [POSITION_W-1:0] s_position,
    input  logic [VALUE_W-1:0]    s_item_value,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_status,
    output logic [VALUE_W-1:0]    m_read_value,
    output logic [LENGTH_W-1:0]   m_list_length
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               m_valid_reg;
    logic               m_status_reg;
    logic [VALUE_W-1:0] m_read_value_reg;

    logic               accept;
    logic               ok;
    logic               do_read;
    chain_op_t          chain_op;
    logic [CMP_W-1:0]   target_ext;
    logic [IDX_W-1:0]   target;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic               pos_in_list;
    logic               pos_at_or_in_list;
    logic               not_full;

    logic [63:0]              item_ext;
    logic [ELEMENT_WIDTH-1:0] item_elem;
    logic [ELEMENT_WIDTH-1:0] read_elem;
    logic [63:0]              read_ext;

    // Accept when the response register is free or drains this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign pos_ext           = CMP_W'(s_position);
    assign cnt_ext           = CMP_W'(count_reg);
    assign pos_in_list       = (pos_ext < cnt_ext);
    assign pos_at_or_in_list = (pos_ext <= cnt_ext);
    assign not_full          = (cnt_ext < CAP_CMP);

    assign item_ext  = 64'(s_item_value);
    assign item_elem = item_ext[ELEMENT_WIDTH-1:0];

    // ------------------------------------------------------------------
    // Decode the request: status, chain operation, new length
    // ------------------------------------------------------------------
    always_comb begin
        ok         = 1'b0;
        do_read    = 1'b0;
        chain_op   = OP_HOLD;
        target_ext = pos_ext;
        count_next = count_reg;
        case (s_action)
            ACT_GET: begin
                ok      = pos_in_list;
                do_read = pos_in_list;
            end
            ACT_SET: begin
                ok = pos_in_list;
                if (pos_in_list) begin
                    chain_op = OP_WRITE;
                end
            end
            ACT_INSERT: begin
                ok = pos_at_or_in_list && not_full;
                if (ok) begin
                    chain_op   = OP_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_DELETE: begin
                ok = pos_in_list;
                if (pos_in_list) begin
                    chain_op   = OP_REMOVE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_PUSH: begin
                // insert at the tail slot
                ok         = not_full;
                target_ext = cnt_ext;
                if (not_full) begin
                    chain_op   = OP_WRITE;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_POP: begin
                // dropping the tail only shortens the list
                ok = (count_reg != '0);
                if (ok) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        // Hold every cell unless a transaction is actually accepted
        if (!accept) begin
            chain_op = OP_HOLD;
        end
    end

    // Target is only acted on when it lies inside the chain
    assign target = target_ext[IDX_W-1:0];

    // ------------------------------------------------------------------
    // Chain of cells; cell k hands its value to both neighbors
    // ------------------------------------------------------------------
    logic [ELEMENT_WIDTH-1:0] cell_value [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] cell_read  [CAPACITY];
    logic [CAPACITY-1:0]      read_col   [ELEMENT_WIDTH];

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ELEMENT_WIDTH-1:0] left_in;
        logic [ELEMENT_WIDTH-1:0] right_in;

        if (k == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_mid_left
            assign left_in = cell_value[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_mid_right
            assign right_in = cell_value[k+1];
        end

        ilid_cell #(
            .ELEMENT_WIDTH (ELEMENT_WIDTH),
            .IDX_W         (IDX_W),
            .INDEX         (k)
        ) u_cell (
            .aclk        (aclk),
            .op          (chain_op),
            .target      (target),
            .new_value   (item_elem),
            .left_value  (left_in),
            .right_value (right_in),
            .value       (cell_value[k]),
            .read_term   (cell_read[k])
        );

        for (genvar b = 0; b < ELEMENT_WIDTH; b++) begin : g_col
            assign read_col[b][k] = cell_read[k][b];
        end
    end

    // Only the addressed cell drives its read term, so OR the columns
    for (genvar b = 0; b < ELEMENT_WIDTH; b++) begin : g_read
        assign read_elem[b] = |read_col[b];
    end

    assign read_ext = 64'(read_elem);

    // ------------------------------------------------------------------
    // Length and response registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg     <= !ok;
            m_read_value_reg <= do_read ? read_ext[VALUE_W-1:0] : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_value  = m_read_value_reg;
    // Length only moves on accept, which cannot happen under a stalled response
    assign m_list_length = LENGTH_W'(count_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length exceeds capacity");

    a_error_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !ok |=> $stable(count_reg))
        else $error("failed request changed the list length");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && ok && (s_action == ACT_INSERT || s_action == ACT_PUSH)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list by one");

    a_error_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg |-> m_read_value_reg == '0)
        else $error("failed request returned a nonzero read value");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !accept)
        else $error("request accepted while a response is stalled");

endmodule
